FILE: design/cidl_pkg.sv
package cidl_pkg;

  // fixed field widths
  localparam int CHANNEL_W = 1;
  localparam int SAMPLE_W  = 24;
  localparam int DELAY_W   = 20;

  // accumulator width for the interpolation, covers the largest Horner value
  localparam int ACC_W = 30;

  // addend chosen for each Horner step
  typedef enum logic [1:0] {
    ADD_B  = 2'd0,
    ADD_A  = 2'd1,
    ADD_Y1 = 2'd2
  } addend_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load_in;
    logic       load_pos;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       coef_en;
    logic       horner_en;
    addend_t    addend;
    logic       finish;
  } cidl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic short_path;
    logic out_free;
  } cidl_status_t;

endpackage

FILE: design/cidl_item_if.sv
interface cidl_item_if import cidl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CHANNEL_W-1:0]       channel;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [DELAY_W-1:0]         delay_q8;
  logic                       bypass;

  modport source (output valid, channel, sample_in, delay_q8, bypass, input ready);
  modport sink (input valid, channel, sample_in, delay_q8, bypass, output ready);
endinterface

FILE: design/cidl_result_if.sv
interface cidl_result_if import cidl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

FILE: design/cidl_ctrl.sv
module cidl_ctrl import cidl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  cidl_status_t status,
  output cidl_cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_POS  = 12'b0000_0000_0010,
    S_RD0  = 12'b0000_0000_0100,
    S_RD1  = 12'b0000_0000_1000,
    S_RD2  = 12'b0000_0001_0000,
    S_RD3  = 12'b0000_0010_0000,
    S_RDW  = 12'b0000_0100_0000,
    S_COEF = 12'b0000_1000_0000,
    S_H1   = 12'b0001_0000_0000,
    S_H2   = 12'b0010_0000_0000,
    S_H3   = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE) && !rst;

  // sequencing and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.addend = ADD_B;
    unique case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = S_POS;
        end
      end
      S_POS: begin
        cmd.load_pos = 1'b1;
        state_next   = status.short_path ? S_FIN : S_RD0;
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd0;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd2;
        state_next = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd3;
        state_next = S_RDW;
      end
      S_RDW: begin
        state_next = S_COEF;
      end
      S_COEF: begin
        cmd.coef_en = 1'b1;
        state_next  = S_H1;
      end
      S_H1: begin
        cmd.horner_en = 1'b1;
        cmd.addend    = ADD_B;
        state_next    = S_H2;
      end
      S_H2: begin
        cmd.horner_en = 1'b1;
        cmd.addend    = ADD_A;
        state_next    = S_H3;
      end
      S_H3: begin
        cmd.horner_en = 1'b1;
        cmd.addend    = ADD_Y1;
        state_next    = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the beat
        cmd.finish = status.out_free;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/cidl_datapath.sv
module cidl_datapath import cidl_pkg::*; #(
  parameter int CHANNELS      = 2,
  parameter int BUFFER_DEPTH  = 4096,
  parameter int FRACTION_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cidl_cmd_t                  cmd,
  output cidl_status_t               status,
  input  logic [CHANNEL_W-1:0]       channel,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [DELAY_W-1:0]         delay_q8,
  input  logic                       bypass,
  cidl_result_if.source              result
);

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int PW  = AW + FRACTION_BITS;
  localparam int MAW = $clog2(CHANNELS * BUFFER_DEPTH);
  localparam int DSW = (PW > DELAY_W) ? PW : DELAY_W;
  localparam int PRW = ACC_W + FRACTION_BITS + 1;

  localparam logic [DSW-1:0] DMIN = DSW'(2) << FRACTION_BITS;
  localparam logic [DSW-1:0] DMAX = DSW'(BUFFER_DEPTH - 4) << FRACTION_BITS;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) << (FRACTION_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SMIN = -ACC_W'(2 ** (SAMPLE_W - 1));

  // captured input beat
  logic [CHANNEL_W-1:0]       ch_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [DELAY_W-1:0]         delay_q;
  logic                       bypass_q;
  logic                       ch_ok;

  // per-channel write pointers and wrap flags
  logic [AW-1:0] wp [CHANNELS];
  logic          wrapped [CHANNELS];
  logic [AW-1:0] wp_cur;
  logic          wrapped_cur;

  // read position
  logic [DSW-1:0]           d_ext;
  logic [DSW-1:0]           d_sat;
  logic [PW-1:0]            pos;
  logic [AW-1:0]            idx_q;
  logic [FRACTION_BITS-1:0] frac_q;

  // sample store
  logic signed [SAMPLE_W-1:0] mem [CHANNELS * BUFFER_DEPTH];
  logic [AW-1:0]              rd_idx;
  logic [MAW-1:0]             maddr;
  logic                       mem_we;
  logic signed [SAMPLE_W-1:0] rdata;
  logic                       rd_valid_q;
  logic                       rd_en_q;
  logic [1:0]                 rd_sel_q;
  logic signed [SAMPLE_W-1:0] y [4];

  // interpolation
  logic signed [ACC_W-1:0] ys0, ys1, ys2, ys3;
  logic signed [ACC_W-1:0] a_q, b_q;
  logic signed [ACC_W-1:0] h_q;
  logic signed [ACC_W-1:0] addend;
  logic signed [PRW-1:0]   prod;
  logic signed [PRW-1:0]   prod_rnd;
  logic signed [ACC_W-1:0] h_next;
  logic signed [ACC_W-1:0] h_half;
  logic signed [SAMPLE_W-1:0] interp;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_data;

  assign ch_ok = (CHANNELS > 1) || (ch_q == '0);

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_q     <= channel;
      sample_q <= sample_in;
      delay_q  <= delay_q8;
      bypass_q <= bypass;
    end
  end

  // pointer of the current channel
  always_comb begin
    wp_cur      = '0;
    wrapped_cur = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (32'(ch_q) == 32'(i)) begin
        wp_cur      = wp[i];
        wrapped_cur = wrapped[i];
      end
    end
  end

  // pointer advance after the store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wp[i]      <= '0;
        wrapped[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (mem_we && (32'(ch_q) == 32'(i))) begin
          wp[i] <= wp[i] + AW'(1);
          if (wp[i] == AW'(BUFFER_DEPTH - 1)) begin
            wrapped[i] <= 1'b1;
          end
        end
      end
    end
  end

  // clamp delay and form read position
  always_comb begin
    d_ext = DSW'(delay_q);
    if (d_ext < DMIN) begin
      d_sat = DMIN;
    end else if (d_ext > DMAX) begin
      d_sat = DMAX;
    end else begin
      d_sat = d_ext;
    end
    pos = {wp_cur, {FRACTION_BITS{1'b0}}} - d_sat[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pos) begin
      idx_q  <= pos[PW-1:FRACTION_BITS];
      frac_q <= pos[FRACTION_BITS-1:0];
    end
  end

  // neighbour address, store port shared by reads and the final write
  assign rd_idx = idx_q + AW'(cmd.rd_sel) - AW'(1);
  assign mem_we = cmd.finish && ch_ok;
  assign maddr  = (MAW'(ch_q) << AW) | MAW'(mem_we ? wp_cur : rd_idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[maddr] <= sample_q;
    end else if (cmd.rd_en) begin
      rdata <= mem[maddr];
    end
  end

  // entries not yet written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_en_q <= 1'b0;
    end else begin
      rd_en_q <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_sel_q   <= cmd.rd_sel;
      rd_valid_q <= wrapped_cur || (rd_idx < wp_cur);
    end
    if (rd_en_q) begin
      y[rd_sel_q] <= rd_valid_q ? rdata : '0;
    end
  end

  // cubic coefficients
  assign ys0 = ACC_W'(y[0]);
  assign ys1 = ACC_W'(y[1]);
  assign ys2 = ACC_W'(y[2]);
  assign ys3 = ACC_W'(y[3]);

  // one Horner step: h = rnd(h * f) + addend
  always_comb begin
    case (cmd.addend)
      ADD_B:   addend = b_q;
      ADD_A:   addend = a_q;
      ADD_Y1:  addend = ys1 <<< 1;
      default: addend = '0;
    endcase
    prod     = PRW'(h_q) * signed'({1'b0, frac_q});
    prod_rnd = (prod + HALF) >>> FRACTION_BITS;
    h_next   = prod_rnd[ACC_W-1:0] + addend;
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_en) begin
      a_q <= ys2 - ys0;
      b_q <= (ys0 <<< 1) - ((ys1 <<< 2) + ys1) + (ys2 <<< 2) - ys3;
      h_q <= -ys0 + ((ys1 <<< 1) + ys1) - ((ys2 <<< 1) + ys2) + ys3;
    end else if (cmd.horner_en) begin
      h_q <= h_next;
    end
  end

  // final halving with rounding and saturation
  always_comb begin
    h_half = (h_q + ACC_W'(1)) >>> 1;
    if (h_half > SMAX) begin
      interp = SMAX[SAMPLE_W-1:0];
    end else if (h_half < SMIN) begin
      interp = SMIN[SAMPLE_W-1:0];
    end else begin
      interp = h_half[SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (!ch_ok) begin
        out_data <= '0;
      end else if (bypass_q) begin
        out_data <= sample_q;
      end else begin
        out_data <= interp;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.sample_out = out_data;

  assign status.short_path = bypass_q || !ch_ok;
  assign status.out_free   = !out_valid || result.ready;

endmodule

FILE: design/cubic_interpolated_delay_line_core.sv
// Multi-channel fractional delay line with Catmull-Rom cubic interpolation.
// item channel: one beat per sample carries the channel, a signed Q1.23
// sample, the delay in samples with FRACTION_BITS fraction bits, and a
// bypass flag. result channel: one beat per item with the Q1.23 output.
// An item is taken only while the controller is idle. A delayed item goes
// through these steps before the next item is accepted: forming the
// read position, four reads of the neighbouring samples through the single
// port of the sample store, a wait for the last read data, one step for the
// coefficients, three Horner steps on the one multiplier, and a final step
// that rounds, writes the new sample and loads the output register.
// Bypass items and items for an unused channel go from the read position
// straight to the final step.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls, the following item holds in its final
// step until the output register is free.
// Reset clears the write pointers and the per-channel wrap flags; entries
// not written since reset read as zero, so no clearing pass is needed.
module cubic_interpolated_delay_line_core import cidl_pkg::*; #(
  parameter int CHANNELS      = 2,
  parameter int BUFFER_DEPTH  = 4096,
  parameter int FRACTION_BITS = 8
) (
  input logic           clk,
  input logic           rst,
  cidl_item_if.sink     item,
  cidl_result_if.source result
);

  cidl_cmd_t    cmd;
  cidl_status_t status;
  logic         in_ready;

  assign item.ready = in_ready;

  cidl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cidl_datapath #(
    .CHANNELS      (CHANNELS),
    .BUFFER_DEPTH  (BUFFER_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .channel   (item.channel),
    .sample_in (item.sample_in),
    .delay_q8  (item.delay_q8),
    .bypass    (item.bypass),
    .result    (result)
  );

endmodule

FILE: bench/tb.sv
module tb;
  import cidl_pkg::*;

  localparam int CHANNELS       = 2;
  localparam int DEPTH          = 4096;
  localparam int FRAC           = 8;
  localparam int ADDR_W         = 12;
  localparam int ADDR_MASK      = DEPTH - 1;
  localparam longint DELAY_MIN  = longint'(2) << FRAC;
  localparam longint DELAY_MAX  = longint'(DEPTH - 4) << FRAC;
  localparam longint SPAN       = longint'(DEPTH) << FRAC;
  localparam int DELAY_FULL     = (1 << DELAY_W) - 1;
  localparam longint OUT_MAX    = 64'sd8388607;
  localparam longint OUT_MIN    = -64'sd8388608;
  localparam logic signed [SAMPLE_W-1:0] FULL_POS = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 24'sh800000;
  localparam int TIMEOUT_CYCLES = 800000;

  logic clk = 1'b0;
  logic rst;

  cidl_item_if   item_bus();
  cidl_result_if result_bus();

  cubic_interpolated_delay_line_core #(
    .CHANNELS      (CHANNELS),
    .BUFFER_DEPTH  (DEPTH),
    .FRACTION_BITS (FRAC)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  // predictor state: per-channel sample history and write pointers
  logic signed [SAMPLE_W-1:0] delay_mem [CHANNELS][DEPTH];
  logic [ADDR_W-1:0]          wr_ptr [CHANNELS];
  logic signed [SAMPLE_W-1:0] last_in [CHANNELS];

  logic signed [SAMPLE_W-1:0] expected_out_q [$];
  logic signed [SAMPLE_W-1:0] want_out;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;
  int cycles        = 0;
  int errors        = 0;
  int results_seen  = 0;
  int beats_sent    = 0;
  int bypass_sent   = 0;
  int clamped_outs  = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_out_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // round to nearest, ties towards plus infinity
  function automatic longint half_up(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // catmull-rom prediction, then store the new sample and advance the pointer
  task automatic predict_beat(input logic [CHANNEL_W-1:0] ch,
                              input logic signed [SAMPLE_W-1:0] smp,
                              input logic [DELAY_W-1:0] dly, input logic byp,
                              output logic signed [SAMPLE_W-1:0] want);
    longint d, pos, frac, y0, y1, y2, y3, ca, cb, cc, acc;
    int unsigned base;
    if (byp) begin
      want = smp;
    end else begin
      d = dly;
      if (d < DELAY_MIN) d = DELAY_MIN;
      if (d > DELAY_MAX) d = DELAY_MAX;
      pos  = (((longint'(wr_ptr[ch]) + DEPTH) << FRAC) - d) & (SPAN - 1);
      base = int'(pos >> FRAC);
      frac = pos & ((longint'(1) << FRAC) - 1);
      y0 = delay_mem[ch][(base - 1) & ADDR_MASK];
      y1 = delay_mem[ch][base & ADDR_MASK];
      y2 = delay_mem[ch][(base + 1) & ADDR_MASK];
      y3 = delay_mem[ch][(base + 2) & ADDR_MASK];
      ca = y2 - y0;
      cb = 2 * y0 - 5 * y1 + 4 * y2 - y3;
      cc = -y0 + 3 * y1 - 3 * y2 + y3;
      // horner evaluation in the fraction
      acc = cc;
      acc = half_up(acc * frac, FRAC) + cb;
      acc = half_up(acc * frac, FRAC) + ca;
      acc = half_up(acc * frac, FRAC) + 2 * y1;
      acc = half_up(acc, 1);
      if (acc > OUT_MAX || acc < OUT_MIN) clamped_outs++;
      if (acc > OUT_MAX) acc = OUT_MAX;
      if (acc < OUT_MIN) acc = OUT_MIN;
      want = acc[SAMPLE_W-1:0];
    end
    delay_mem[ch][wr_ptr[ch]] = smp;
    wr_ptr[ch] = wr_ptr[ch] + 1'b1;
  endtask

  // send one beat, with random gaps before it; returns at a falling edge
  task automatic send_beat(input logic [CHANNEL_W-1:0] ch,
                           input logic signed [SAMPLE_W-1:0] smp,
                           input logic [DELAY_W-1:0] dly, input logic byp);
    logic signed [SAMPLE_W-1:0] want;
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk);
    end
    item_bus.valid     <= 1'b1;
    item_bus.channel   <= ch;
    item_bus.sample_in <= smp;
    item_bus.delay_q8  <= dly;
    item_bus.bypass    <= byp;
    do @(posedge clk); while (!item_bus.ready);
    predict_beat(ch, smp, dly, byp, want);
    expected_out_q.push_back(want);
    beats_sent++;
    if (byp) bypass_sent++;
    last_in[ch] = smp;
    @(negedge clk);
  endtask

  // random beat, mostly with delays that land on written history
  task automatic send_random_beat();
    logic [CHANNEL_W-1:0] ch;
    logic signed [SAMPLE_W-1:0] smp;
    logic [DELAY_W-1:0] dly;
    logic byp;
    int unsigned pick, reach;
    ch   = CHANNEL_W'($urandom_range(CHANNELS - 1, 0));
    byp  = ($urandom_range(99) < 15);
    pick = $urandom_range(99);
    if (pick < 55) smp = SAMPLE_W'($urandom);
    else if (pick < 70) smp = $urandom_range(1) ? FULL_POS : FULL_NEG;
    else smp = last_in[ch] + SAMPLE_W'($urandom_range(4095)) - SAMPLE_W'(2048);
    pick  = $urandom_range(99);
    reach = (int'(wr_ptr[ch]) + 4) << FRAC;
    if (reach > DELAY_FULL) reach = DELAY_FULL;
    if (pick < 60) dly = DELAY_W'($urandom_range(reach, 0));
    else if (pick < 75) dly = DELAY_W'($urandom);
    else if (pick < 87) dly = DELAY_W'($urandom_range(1023, 0));
    else dly = DELAY_W'($urandom_range(DELAY_FULL, int'(DELAY_MAX) - 512));
    send_beat(ch, smp, dly, byp);
  endtask

  // sender pause until every result is back
  task automatic wait_for_results();
    item_bus.valid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // reads of history never written since reset
  task automatic test_unwritten_reads();
    send_beat(1'b0, 24'sh123456, DELAY_W'(DELAY_MAX), 1'b0);
    send_beat(1'b1, -24'sd5, '0, 1'b0);
    send_beat(1'b1, 24'sd1, DELAY_W'(DELAY_FULL), 1'b0);
  endtask

  // full-scale samples, delay clamping, fraction corners, both channels
  task automatic test_extremes();
    send_beat(1'b0, FULL_POS, DELAY_W'(DELAY_FULL), 1'b1);
    send_beat(1'b0, FULL_NEG, '0, 1'b1);
    send_beat(1'b0, FULL_POS, 20'd640, 1'b1);
    send_beat(1'b0, FULL_NEG, 20'd1, 1'b1);
    send_beat(1'b0, FULL_NEG, '0, 1'b0);
    send_beat(1'b0, FULL_POS, 20'd640, 1'b0);
    send_beat(1'b0, FULL_NEG, 20'd641, 1'b0);
    send_beat(1'b0, FULL_POS, 20'd767, 1'b0);
    send_beat(1'b0, FULL_NEG, 20'd513, 1'b0);
    send_beat(1'b0, FULL_POS, 20'd896, 1'b0);
    send_beat(1'b0, 24'sd0, DELAY_W'(DELAY_MAX), 1'b0);
    send_beat(1'b0, -24'sd1, DELAY_W'(DELAY_FULL), 1'b0);
    send_beat(1'b1, 24'sd0, 20'd640, 1'b1);
    send_beat(1'b1, -24'sd1, 20'd512, 1'b1);
    send_beat(1'b1, FULL_POS, 20'd640, 1'b0);
    send_beat(1'b1, FULL_NEG, 20'd1152, 1'b0);
    wait_for_results();
  endtask

  task automatic test_random(input int n, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n) send_random_beat();
    wait_for_results();
  endtask

  // long receiver stall while beats keep coming, so the input backs up
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_cycles = 200;
    @(negedge clk);
    repeat (12) send_random_beat();
    wait_for_results();
  endtask

  // receiver: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_bus.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      results_seen++;
      if (expected_out_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat %0d: sample_out %0d", results_seen,
                   result_bus.sample_out);
      end else begin
        want_out = expected_out_q.pop_front();
        if (result_bus.sample_out !== want_out) begin
          errors++;
          if (errors <= 10)
            $display("result %0d sample_out: expected %0d, got %0d", results_seen,
                     want_out, result_bus.sample_out);
        end
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    item_bus.valid      = 1'b0;
    item_bus.channel    = '0;
    item_bus.sample_in  = '0;
    item_bus.delay_q8   = '0;
    item_bus.bypass     = 1'b0;
    result_bus.ready    = 1'b0;
    foreach (delay_mem[c, i]) delay_mem[c][i] = '0;
    foreach (wr_ptr[c]) begin
      wr_ptr[c]  = '0;
      last_in[c] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_unwritten_reads();
    test_extremes();
    test_random(610, 31, 66);
    test_output_backpressure();
    test_random(610, 66, 31);
    test_random(610, 0, 0);
    wait_for_results();
    repeat (24) @(posedge clk);

    $display("%0d sample beats (%0d bypass) and %0d results checked, %0d mismatches",
             beats_sent, bypass_sent, results_seen, errors);
    $display("delays from below 2 to above the buffer limit, %0d saturated outputs",
             clamped_outs);
    if (errors == 0 && expected_out_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: cubic_interpolated_delay_line_core.f
design/cidl_pkg.sv
design/cidl_item_if.sv
design/cidl_result_if.sv
design/cidl_ctrl.sv
design/cidl_datapath.sv
design/cubic_interpolated_delay_line_core.sv
bench/tb.sv
